>>> rtl/assert_macros.svh
// assertion macros shared by the matcher rtl
// no dependencies; included by the files that hold concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, masked while reset is asserted
`define MPBM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// clocked check that also holds during reset
`define MPBM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/mpbm_pkg.sv
// shared types and constants of the multi-pattern byte matcher
// no dependencies; imported by every other rtl file except assert_macros.svh
`default_nettype none

package mpbm_pkg;

    localparam int DEF_PATTERN_COUNT = 3;
    localparam int DEF_MAX_LENGTH    = 8;

    localparam int REG_PATTERNS = 3;
    localparam int BYTE_W       = 8;
    localparam int PATTERN_W    = 64;
    localparam int LEN_W        = 4;
    localparam int OFFSET_W     = 16;
    localparam int WHICH_W      = 2;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_A = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_B = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_C = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_A  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_B  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_C  = 3'd5;

    typedef struct packed {
        logic [REG_PATTERNS-1:0][PATTERN_W-1:0] pattern;
        logic [REG_PATTERNS-1:0][LEN_W-1:0]     length;
    } t_cfg;

    typedef struct packed {
        logic                found;
        logic [WHICH_W-1:0]  which_pattern;
        logic [OFFSET_W-1:0] offset;
        logic                ended;
    } t_result;

endpackage

`default_nettype wire

>>> rtl/mpbm_in_if.sv
// input channel of the matcher: one stream byte or end-of-input marker
// depends on mpbm_pkg
`default_nettype none

interface mpbm_in_if import mpbm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_input;

    modport source (output valid, output data_byte, output end_of_input, input ready);
    modport sink (input valid, input data_byte, input end_of_input, output ready);
endinterface

`default_nettype wire

>>> rtl/mpbm_out_if.sv
// result channel of the matcher: one result per input transaction
// depends on mpbm_pkg
`default_nettype none

interface mpbm_out_if import mpbm_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                found;
    logic [WHICH_W-1:0]  which_pattern;
    logic [OFFSET_W-1:0] offset;
    logic                ended;

    modport source (output valid, output found, output which_pattern, output offset,
                    output ended, input ready);
    modport sink (input valid, input found, input which_pattern, input offset,
                  input ended, output ready);
endinterface

`default_nettype wire

>>> rtl/multi_pattern_byte_matcher.sv
// an accepted input transaction is held in the input register, then its result in the result register
// one byte per cycle while the result channel is not stalled; the window compare is combinational
// an input register and a result register part the two channels, so one input is taken
// while a result waits
// reset (synchronous, active low) clears the patterns, lengths, window and counts
// top level of the matcher; depends on mpbm_pkg, the channel interfaces,
// mpbm_cfg_regs, mpbm_search and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module multi_pattern_byte_matcher import mpbm_pkg::*; #(
    parameter int PATTERN_COUNT = DEF_PATTERN_COUNT,
    parameter int MAX_LENGTH    = DEF_MAX_LENGTH
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    mpbm_in_if.sink                    i_in,
    mpbm_out_if.source                 o_out
);

    t_cfg              cfg;
    t_result           result;
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_eoi;
    logic              r_out_valid;
    t_result           r_out;
    logic              advance;
    logic              in_take;

    mpbm_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    mpbm_search #(
        .PATTERN_COUNT (PATTERN_COUNT),
        .MAX_LENGTH    (MAX_LENGTH)
    ) u_search (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (advance),
        .i_data_byte    (r_in_byte),
        .i_end_of_input (r_in_eoi),
        .i_cfg          (cfg),
        .o_result       (result)
    );

    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign in_take    = i_in.valid && i_in.ready;
    assign i_in.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_in.data_byte;
            r_in_eoi  <= i_in.end_of_input;
        end
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.found         = r_out.found;
    assign o_out.which_pattern = r_out.which_pattern;
    assign o_out.offset        = r_out.offset;
    assign o_out.ended         = r_out.ended;

    `MPBM_ASSERT(a_stall_holds_input, i_clk, i_rst_n, (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in_byte) && $stable(r_in_eoi)), "input stage lost a pending byte")
    `MPBM_ASSERT(a_advance_loads_out, i_clk, i_rst_n, advance |=> r_out_valid, "result register not loaded on advance")

endmodule

`default_nettype wire

>>> rtl/mpbm_cfg_regs.sv
// configuration register file: pattern bytes and pattern lengths
// depends on mpbm_pkg
`default_nettype none

module mpbm_cfg_regs import mpbm_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PATTERN_A: r_cfg.pattern[0] <= i_cfg_data;
                CFG_PATTERN_B: r_cfg.pattern[1] <= i_cfg_data;
                CFG_PATTERN_C: r_cfg.pattern[2] <= i_cfg_data;
                CFG_LENGTH_A:  r_cfg.length[0]  <= i_cfg_data[LEN_W-1:0];
                CFG_LENGTH_B:  r_cfg.length[1]  <= i_cfg_data[LEN_W-1:0];
                CFG_LENGTH_C:  r_cfg.length[2]  <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

>>> rtl/mpbm_search.sv
// search state (byte window, fill and byte counts) and suffix compare
// depends on mpbm_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module mpbm_search import mpbm_pkg::*; #(
    parameter int PATTERN_COUNT = DEF_PATTERN_COUNT,
    parameter int MAX_LENGTH    = DEF_MAX_LENGTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_step,
    input  wire logic [BYTE_W-1:0] i_data_byte,
    input  wire logic              i_end_of_input,
    input  wire t_cfg              i_cfg,
    output t_result                o_result
);

    localparam int FILL_W = $clog2(MAX_LENGTH + 1);

    logic [BYTE_W-1:0]   r_window [MAX_LENGTH];
    logic [FILL_W-1:0]   r_fill;
    logic [OFFSET_W-1:0] r_count;

    logic [BYTE_W-1:0]   win_shift [MAX_LENGTH];
    logic [FILL_W-1:0]   fill_inc;
    logic [OFFSET_W-1:0] count_inc;
    logic [REG_PATTERNS-1:0] hit;
    logic                hit_any;
    logic                clear;

    always_comb begin
        win_shift[0] = i_data_byte;
        for (int j = 1; j < MAX_LENGTH; j++) begin
            win_shift[j] = r_window[j-1];
        end
        fill_inc  = (r_fill < FILL_W'(MAX_LENGTH)) ? r_fill + 1'b1 : r_fill;
        count_inc = (r_count != '1) ? r_count + 1'b1 : r_count;
    end

    for (genvar p = 0; p < REG_PATTERNS; p++) begin : g_pat
        if (p < PATTERN_COUNT) begin : g_on
            logic [LEN_W-1:0] len;
            logic             sel;
            assign len = i_cfg.length[p];

            always_comb begin
                logic ok;
                sel = 1'b0;
                for (int l = 1; l <= MAX_LENGTH; l++) begin
                    ok = 1'b1;
                    for (int j = 0; j < l; j++) begin
                        ok = ok & (win_shift[j] == i_cfg.pattern[p][BYTE_W*(l-1-j) +: BYTE_W]);
                    end
                    sel = sel | ((len == LEN_W'(l)) & ok);
                end
            end

            // zero length never equals any l, so it stays disabled
            assign hit[p] = sel && (len <= LEN_W'(fill_inc));
        end else begin : g_off
            assign hit[p] = 1'b0;
        end
    end

    always_comb begin
        o_result.which_pattern = '0;
        for (int p = REG_PATTERNS - 1; p >= 0; p--) begin
            if (hit[p]) begin
                o_result.which_pattern = WHICH_W'(p);
            end
        end
        hit_any = |hit;
        if (i_end_of_input) begin
            o_result.found         = 1'b0;
            o_result.which_pattern = '0;
            o_result.offset        = r_count;
            o_result.ended         = 1'b1;
        end else begin
            o_result.found  = hit_any;
            o_result.offset = count_inc;
            o_result.ended  = 1'b0;
        end
        clear = i_end_of_input || hit_any;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < MAX_LENGTH; j++) begin
                r_window[j] <= '0;
            end
            r_fill  <= '0;
            r_count <= '0;
        end else if (i_step) begin
            for (int j = 0; j < MAX_LENGTH; j++) begin
                r_window[j] <= clear ? '0 : win_shift[j];
            end
            r_fill  <= clear ? '0 : fill_inc;
            r_count <= clear ? '0 : count_inc;
        end
    end

    `MPBM_ASSERT(a_eoi_clears, i_clk, i_rst_n, (i_step && i_end_of_input) |=> (r_fill == '0 && r_count == '0), "end of input did not restart the search")
    `MPBM_ASSERT(a_match_clears, i_clk, i_rst_n, (i_step && o_result.found) |=> (r_fill == '0 && r_count == '0), "match did not restart the search")
    `MPBM_ASSERT(a_found_xor_ended, i_clk, i_rst_n, !(o_result.found && o_result.ended), "result both found and ended")
    `MPBM_ASSERT(a_which_idle, i_clk, i_rst_n, o_result.found || (o_result.which_pattern == '0), "pattern index set without a match")

endmodule

`default_nettype wire

>>> tb/sv/multi_pattern_byte_matcher_tb.sv
`timescale 1ns / 1ps
// self-checking testbench of multi_pattern_byte_matcher: streams byte and end-of-input
// transactions under random back-pressure and checks each result against a local model
// depends on mpbm_pkg, mpbm_in_if, mpbm_out_if and the matcher rtl

module multi_pattern_byte_matcher_tb;
    import mpbm_pkg::*;

    localparam int MAX_LEN        = DEF_MAX_LENGTH;
    localparam int SEARCHED       = (DEF_PATTERN_COUNT < REG_PATTERNS) ?
                                    DEF_PATTERN_COUNT : REG_PATTERNS;
    localparam int CYCLE_LIMIT    = 1000000;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_ITEMS    = 220;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              end_of_input;
    } t_stream_item;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    mpbm_in_if  in_if ();
    mpbm_out_if out_if ();

    multi_pattern_byte_matcher dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    // matcher model state
    logic [PATTERN_W-1:0] pat_bytes [REG_PATTERNS];
    logic [LEN_W-1:0]     pat_len [REG_PATTERNS];
    logic [BYTE_W-1:0]    hist_q [MAX_LEN];
    logic [LEN_W-1:0]     fill_cnt;
    logic [OFFSET_W-1:0]  seen_cnt;

    t_stream_item byte_pend_q [$];
    t_result      result_q [$];

    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic in_fire        = 1'b0;
    int   error_cnt      = 0;
    int   cycle_cnt      = 0;
    int   bytes_in       = 0;
    int   hit_cnt        = 0;
    int   end_cnt        = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic void clear_search();
        for (int k = 0; k < MAX_LEN; k++) hist_q[k] = '0;
        fill_cnt = '0;
        seen_cnt = '0;
    endfunction

    function automatic logic pattern_ends_here(input int p);
        int plen;
        plen = pat_len[p];
        if (plen == 0 || plen > MAX_LEN || plen > fill_cnt) return 1'b0;
        for (int k = 0; k < plen; k++)
            if (hist_q[plen-1-k] != pat_bytes[p][8*k +: 8]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic void advance_search(input logic [BYTE_W-1:0] b, input logic eoi);
        t_result r;
        r = '0;
        if (eoi) begin
            r.offset = seen_cnt;
            r.ended  = 1'b1;
            clear_search();
            end_cnt++;
        end else begin
            for (int k = MAX_LEN - 1; k > 0; k--) hist_q[k] = hist_q[k-1];
            hist_q[0] = b;
            if (fill_cnt < MAX_LEN) fill_cnt++;
            if (seen_cnt != '1) seen_cnt++;
            r.offset = seen_cnt;
            // lowest index wins
            for (int p = 0; p < SEARCHED; p++) begin
                if (!r.found && pattern_ends_here(p)) begin
                    r.found         = 1'b1;
                    r.which_pattern = WHICH_W'(p);
                end
            end
            if (r.found) begin
                clear_search();
                hit_cnt++;
            end
        end
        result_q.push_back(r);
    endfunction

    function automatic void queue_byte(input logic [BYTE_W-1:0] b, input logic eoi);
        t_stream_item it;
        it.data_byte    = b;
        it.end_of_input = eoi;
        byte_pend_q.push_back(it);
    endfunction

    // small alphabet most of the time so that partial and overlapping matches occur
    function automatic logic [BYTE_W-1:0] pick_byte();
        if ($urandom_range(3) == 0) return BYTE_W'($urandom);
        return 8'h41 + BYTE_W'($urandom_range(2));
    endfunction

    function automatic void queue_random_stream(input int n);
        int p;
        int plen;
        int sel;
        int cut;
        while (byte_pend_q.size() < n) begin
            sel  = $urandom_range(99);
            p    = $urandom_range(REG_PATTERNS - 1);
            plen = pat_len[p];
            if (sel < 45 && plen >= 1 && plen <= MAX_LEN) begin
                repeat ($urandom_range(2)) queue_byte(pick_byte(), 1'b0);
                for (int k = 0; k < plen; k++) queue_byte(pat_bytes[p][8*k +: 8], 1'b0);
            end else if (sel < 65 && plen >= 2 && plen <= MAX_LEN) begin
                // broken pattern: a prefix then an arbitrary byte
                cut = $urandom_range(plen - 1, 1);
                for (int k = 0; k < cut; k++) queue_byte(pat_bytes[p][8*k +: 8], 1'b0);
                queue_byte(pick_byte(), 1'b0);
            end else if (sel < 94) begin
                queue_byte(pick_byte(), 1'b0);
            end else begin
                queue_byte(BYTE_W'($urandom), 1'b1);
            end
        end
    endfunction

    // caller stands just after a falling edge; returns at the next one with the enable high
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        if (idx <= CFG_PATTERN_C)
            pat_bytes[idx] = val;
        else if (idx <= CFG_LENGTH_C)
            pat_len[idx - CFG_LENGTH_A] = val[LEN_W-1:0];
        @(negedge i_clk);
    endtask

    task automatic configure(input logic [PATTERN_W-1:0] pa, pb, pc,
                             input logic [LEN_W-1:0] la, lb, lc);
        write_reg(CFG_PATTERN_A, pa);
        write_reg(CFG_PATTERN_B, pb);
        write_reg(CFG_PATTERN_C, pc);
        // upper bits of a length write are don't-care
        write_reg(CFG_LENGTH_A, {32'($urandom), 28'($urandom), la});
        write_reg(CFG_LENGTH_B, {32'($urandom), 28'($urandom), lb});
        write_reg(CFG_LENGTH_C, {32'($urandom), 28'($urandom), lc});
        write_reg(CFG_SPARE_LO, {$urandom, $urandom});
        write_reg(CFG_SPARE_HI, {$urandom, $urandom});
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (byte_pend_q.size() != 0 || in_if.valid || result_q.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    // driver
    always @(negedge i_clk) begin : drive_bytes
        t_stream_item nxt;
        if (i_rst_n && (in_fire || !in_if.valid)) begin
            if (byte_pend_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = byte_pend_q.pop_front();
                in_if.valid        <= 1'b1;
                in_if.data_byte    <= nxt.data_byte;
                in_if.end_of_input <= nxt.end_of_input;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
        out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // input side: every accepted transaction goes through the model
    always @(posedge i_clk) begin
        in_fire <= i_rst_n && in_if.valid && in_if.ready;
        if (i_rst_n && in_if.valid && in_if.ready) begin
            advance_search(in_if.data_byte, in_if.end_of_input);
            bytes_in++;
        end
    end

    // monitor
    always @(posedge i_clk) begin : check_results
        t_result want;
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else if (i_rst_n && out_if.valid && out_if.ready) begin
            if (result_q.size() == 0) begin
                $error("result transaction with no expected result pending");
                error_cnt++;
            end else begin
                want = result_q.pop_front();
                if (out_if.found !== want.found) begin
                    $error("found: expected %0d, got %0d", want.found, out_if.found);
                    error_cnt++;
                end
                if (out_if.which_pattern !== want.which_pattern) begin
                    $error("which_pattern: expected %0d, got %0d",
                           want.which_pattern, out_if.which_pattern);
                    error_cnt++;
                end
                if (out_if.offset !== want.offset) begin
                    $error("offset: expected %0d, got %0d", want.offset, out_if.offset);
                    error_cnt++;
                end
                if (out_if.ended !== want.ended) begin
                    $error("ended: expected %0d, got %0d", want.ended, out_if.ended);
                    error_cnt++;
                end
            end
        end
    end

    initial begin : stimulus
        logic [PATTERN_W-1:0] pv [REG_PATTERNS];
        logic [LEN_W-1:0]     lv [REG_PATTERNS];
        int                   lsel;

        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_idx          = '0;
        i_cfg_data         = '0;
        in_if.valid        = 1'b0;
        in_if.data_byte    = '0;
        in_if.end_of_input = 1'b0;
        out_if.ready       = 1'b0;
        for (int i = 0; i < REG_PATTERNS; i++) begin
            pat_bytes[i] = '0;
            pat_len[i]   = '0;
        end
        clear_search();

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // two patterns ending together, single-byte pattern, back-to-back end of input,
        // full-length all-ones pattern
        configure(64'h4241, 64'h42, '1, 4'd2, 4'd1, 4'd8);
        queue_byte(8'h41, 1'b0);
        queue_byte(8'h42, 1'b0);
        queue_byte(8'h42, 1'b0);
        queue_byte(8'h41, 1'b0);
        queue_byte(8'hFF, 1'b1);
        queue_byte(8'h00, 1'b1);
        repeat (8) queue_byte(8'hFF, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h55, 1'b1);
        wait_idle();

        // lengths above the maximum and zero never match
        configure('0, '1, '0, 4'd15, 4'd0, 4'd9);
        repeat (8) queue_byte(8'h00, 1'b0);
        queue_byte(8'hAA, 1'b1);
        wait_idle();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            send_idle_pct  = (ph < 2) ? 14 : (ph < 4) ? 64 : 0;
            recv_stall_pct = (ph < 2) ? 64 : (ph < 4) ? 14 : 0;
            for (int i = 0; i < REG_PATTERNS; i++) begin
                for (int k = 0; k < MAX_LEN; k++)
                    pv[i][8*k +: 8] = (ph % 3 == 0) ? BYTE_W'($urandom) : pick_byte();
                lsel = $urandom_range(99);
                if (ph % 3 == 1)
                    lv[i] = 4'd8;
                else if (ph % 3 == 2)
                    lv[i] = LEN_W'($urandom_range(3, 1));
                else if (lsel < 10)
                    lv[i] = 4'd0;
                else if (lsel < 20)
                    lv[i] = LEN_W'($urandom_range(15, 9));
                else
                    lv[i] = LEN_W'($urandom_range(8, 1));
            end
            configure(pv[0], pv[1], pv[2], lv[0], lv[1], lv[2]);
            queue_random_stream(PHASE_ITEMS);
            wait_idle();
        end

        $display("covered %0d input transactions with %0d pattern hits and %0d end-of-input",
                 bytes_in, hit_cnt, end_cnt);
        $display("results over eight register settings, including zero and over-long lengths");
        if (error_cnt == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
